/* design/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants for the keyed ttl slot table
// Item payloads, status codes and action codes.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int SLOTS = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int OUT_MAX = 8;
   localparam logic [9:0] MS_PER_S = 10'd1000;

   typedef enum logic [1:0] {
      ACT_UPSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_REAP   = 2'd2,
      ACT_LIST   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_CREATED = 3'd0,
      ST_UPDATED = 3'd1,
      ST_DELETED = 3'd2,
      ST_MISSING = 3'd3,
      ST_REAP_NONE = 3'd4,
      ST_REAP_CLR = 3'd5,
      ST_LIST = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [63:0]        key_high;
      logic [63:0]        key_low;
      logic [47:0]        now_ms;
      logic [31:0]        ttl_seconds;
      logic signed [31:0] position;
      logic               position_given;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         slot;
      logic [3:0]         live_count;
      logic               entry_valid;
      logic [63:0]        entry_key_high;
      logic [63:0]        entry_key_low;
      logic signed [31:0] entry_position;
      logic [31:0]        entry_ttl;
      logic [47:0]        entry_arrival;
      logic               last;
   } rsp_type;

endpackage

/* design/kts_req_if.sv */
// ----------------------------------------------------------------------------
// kts_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface kts_req_if;
   logic              valid;
   logic              ready;
   kts_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/kts_rsp_if.sv */
// ----------------------------------------------------------------------------
// kts_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface kts_rsp_if;
   logic              valid;
   logic              ready;
   kts_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/keyed_ttl_slot_table.sv */
// ----------------------------------------------------------------------------
// keyed_ttl_slot_table: eight-slot keyed table with time-to-live
// Upsert, delete, reap and sorted list over a small register table, done by
// a sequencer stepping one slot per cycle through one shared compare unit.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  req      | in  | action, key, now_ms, ttl_seconds, position
//  rsp      | out | status, slot, live_count, entry fields, last
//
//  Upsert/delete/reap: one scan over all slots (upsert a second scan to
//  pick a slot when the key is new), then one result. List: one scan to
//  count, then per output entry one scan picking the next entry in order.
//  The slot scan through the shared compare unit sets the rate.
//  Reset clears all slots at once. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module keyed_ttl_slot_table (
   input logic clock,
   input logic reset,
   kts_req_if.sink req,
   kts_rsp_if.source rsp
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIND  = 7'b0000010,
      S_PICK  = 7'b0000100,
      S_REAP  = 7'b0001000,
      S_COUNT = 7'b0010000,
      S_SORT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   localparam int SW = kts_pkg::SLOT_W;
   localparam int CW = kts_pkg::CNT_W;

   state_type state_ff, state_in;
   kts_pkg::req_type rq_ff, rq_in;
   kts_pkg::rsp_type out_ff, out_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [3:0] emit_ff, emit_in;
   logic found_ff, found_in;
   logic [SW-1:0] best_ff, best_in;
   logic best_v_ff, best_v_in;
   logic [1:0] best_cls_ff, best_cls_in;
   logic [47:0] best_age_ff, best_age_in;
   logic any_ff, any_in;
   logic have_prev_ff, have_prev_in;
   logic [SW-1:0] prev_ff, prev_in;

   logic [63:0] kh_ff [kts_pkg::SLOTS];
   logic [63:0] kl_ff [kts_pkg::SLOTS];
   logic [47:0] arr_ff [kts_pkg::SLOTS];
   logic [31:0] ttl_ff [kts_pkg::SLOTS];
   logic [31:0] pos_ff [kts_pkg::SLOTS];

   // shared unit: per-slot evaluation of the slot addressed by idx_ff
   logic cur_used, cur_exp, cur_match, cur_live;
   logic [47:0] cur_age;
   logic [57:0] ttl_ms;
   logic [31:0] pa, pb;
   logic cur_after_prev, cur_before_best;
   logic last_idx;
   logic wr_en, clr_en;
   logic [SW-1:0] wr_idx;
   logic [1:0] cur_cls;

   always_comb begin
      cur_used = (kh_ff[idx_ff] | kl_ff[idx_ff]) != 64'd0;
      ttl_ms = 58'(ttl_ff[idx_ff]) * 58'(kts_pkg::MS_PER_S);
      cur_age = (rq_ff.now_ms < arr_ff[idx_ff]) ? 48'd0 : rq_ff.now_ms - arr_ff[idx_ff];
      cur_exp = cur_used && ttl_ff[idx_ff] != 32'd0 && rq_ff.now_ms >= arr_ff[idx_ff]
                && 58'(cur_age) >= ttl_ms;
      cur_live = cur_used && !cur_exp;
      cur_match = cur_used && kh_ff[idx_ff] == rq_ff.key_high
                  && kl_ff[idx_ff] == rq_ff.key_low;
      cur_cls = !cur_used ? 2'd0 : (cur_exp ? 2'd1 : 2'd2);
      pa = pos_ff[idx_ff] ^ 32'h8000_0000;
      pb = pos_ff[prev_ff] ^ 32'h8000_0000;
      cur_after_prev = !have_prev_ff || (pa != pb ? pa > pb :
                       (kh_ff[idx_ff] != kh_ff[prev_ff] ? kh_ff[idx_ff] > kh_ff[prev_ff] :
                        kl_ff[idx_ff] > kl_ff[prev_ff]));
      pb = pos_ff[best_ff] ^ 32'h8000_0000;
      cur_before_best = !best_v_ff || (pa != pb ? pa < pb :
                       (kh_ff[idx_ff] != kh_ff[best_ff] ? kh_ff[idx_ff] < kh_ff[best_ff] :
                        kl_ff[idx_ff] < kl_ff[best_ff]));
      last_idx = idx_ff == SW'(kts_pkg::SLOTS - 1);
   end

   always_comb begin
      state_in = state_ff;
      rq_in = rq_ff;
      out_in = out_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      emit_in = emit_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_v_in = best_v_ff;
      best_cls_in = best_cls_ff;
      best_age_in = best_age_ff;
      any_in = any_ff;
      have_prev_in = have_prev_ff;
      prev_in = prev_ff;
      wr_en = 1'b0;
      clr_en = 1'b0;
      wr_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               rq_in = req.payload;
               idx_in = '0;
               found_in = 1'b0;
               best_v_in = 1'b0;
               any_in = 1'b0;
               cnt_in = '0;
               emit_in = '0;
               have_prev_in = 1'b0;
               unique case (kts_pkg::action_type'(req.payload.action))
                  kts_pkg::ACT_UPSERT, kts_pkg::ACT_DELETE: state_in = S_FIND;
                  kts_pkg::ACT_REAP: state_in = S_REAP;
                  default: state_in = S_COUNT;
               endcase
            end
         end
         S_FIND: begin
            if (!found_ff && cur_match) begin
               found_in = 1'b1;
               best_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in = '0;
               out_in = '0;
               out_in.last = 1'b1;
               if (rq_ff.action == kts_pkg::ACT_DELETE) begin
                  state_in = S_OUT;
                  if (found_in) begin
                     clr_en = 1'b1;
                     wr_idx = best_in;
                     out_in.status = kts_pkg::ST_DELETED;
                     out_in.slot = 3'(best_in);
                  end else begin
                     out_in.status = kts_pkg::ST_MISSING;
                  end
               end else if (found_in) begin
                  wr_en = 1'b1;
                  wr_idx = best_in;
                  out_in.status = kts_pkg::ST_UPDATED;
                  out_in.slot = 3'(best_in);
                  state_in = S_OUT;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_PICK: begin
            // class 0 free, 1 expired, 2 live (oldest wins); lower class wins, first on ties
            if (!best_v_ff || cur_cls < best_cls_ff
                || (cur_cls == best_cls_ff && cur_cls == 2'd2 && cur_age > best_age_ff)) begin
               best_in = idx_ff;
               best_v_in = 1'b1;
               best_cls_in = cur_cls;
               best_age_in = cur_age;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               wr_en = 1'b1;
               wr_idx = best_in;
               out_in = '0;
               out_in.last = 1'b1;
               out_in.status = kts_pkg::ST_CREATED;
               out_in.slot = 3'(best_in);
               state_in = S_OUT;
            end
         end
         S_REAP: begin
            if (cur_exp) begin
               clr_en = 1'b1;
               any_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               out_in = '0;
               out_in.last = 1'b1;
               out_in.status = any_in ? kts_pkg::ST_REAP_CLR : kts_pkg::ST_REAP_NONE;
               state_in = S_OUT;
            end
         end
         S_COUNT: begin
            if (cur_live) cnt_in = cnt_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in = '0;
               if (cnt_in == '0) begin
                  out_in = '0;
                  out_in.status = kts_pkg::ST_LIST;
                  out_in.last = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SORT;
               end
            end
         end
         S_SORT: begin
            // selection: smallest live entry strictly after the previous one
            if (cur_live && cur_after_prev && cur_before_best) begin
               best_in = idx_ff;
               best_v_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in = '0;
               emit_in = emit_ff + 1'b1;
               out_in.status = kts_pkg::ST_LIST;
               out_in.slot = 3'(best_in);
               out_in.live_count = (32'(cnt_ff) > 15) ? 4'd15 : 4'(cnt_ff);
               out_in.entry_valid = 1'b1;
               out_in.entry_key_high = kh_ff[best_in];
               out_in.entry_key_low = kl_ff[best_in];
               out_in.entry_position = pos_ff[best_in];
               out_in.entry_ttl = ttl_ff[best_in];
               out_in.entry_arrival = arr_ff[best_in];
               out_in.last = (32'(emit_in) == 32'(cnt_ff)) || (32'(emit_in) == kts_pkg::OUT_MAX);
               have_prev_in = 1'b1;
               prev_in = best_in;
               best_v_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               if (out_ff.last) state_in = S_IDLE;
               else state_in = S_SORT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < kts_pkg::SLOTS; i++) begin
            kh_ff[i] <= '0;
            kl_ff[i] <= '0;
            arr_ff[i] <= '0;
            ttl_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (clr_en) begin
            kh_ff[wr_idx] <= '0;
            kl_ff[wr_idx] <= '0;
            arr_ff[wr_idx] <= '0;
            ttl_ff[wr_idx] <= '0;
            pos_ff[wr_idx] <= '0;
         end else if (wr_en) begin
            arr_ff[wr_idx] <= rq_ff.now_ms;
            ttl_ff[wr_idx] <= rq_ff.ttl_seconds;
            if (state_ff == S_PICK) begin
               kh_ff[wr_idx] <= rq_ff.key_high;
               kl_ff[wr_idx] <= rq_ff.key_low;
               pos_ff[wr_idx] <= rq_ff.position_given ? rq_ff.position : 32'sd0;
            end
         end
      end
      rq_ff <= rq_in;
      out_ff <= out_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      emit_ff <= emit_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_v_ff <= best_v_in;
      best_cls_ff <= best_cls_in;
      best_age_ff <= best_age_in;
      any_ff <= any_in;
      have_prev_ff <= have_prev_in;
      prev_ff <= prev_in;
   end

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = state_ff == S_OUT;
   assign rsp.payload = out_ff;

`ifndef ASSERT_OFF
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.payload.last |=> req.ready)
      else $error("no return to idle after last item");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.entry_valid |-> rsp.payload.live_count != 4'd0)
      else $error("listed entry with zero count");
`endif

endmodule
